[sv/gradient_palette_lookup_assert.svh]
// Assertion macros for the palette lookup checker
`ifndef GRADIENT_PALETTE_LOOKUP_ASSERT_SVH
`define GRADIENT_PALETTE_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset
`define GPL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("gpl assertion failed");

// Next-cycle implication, sampled on i_clk, off while in reset
`define GPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("gpl assertion failed");

`endif

[sv/gpl_pkg.sv]
// Shared types and constants of the gradient palette lookup
package gpl_pkg;

    localparam int MAX_STOPS = 7;
    localparam int FRAC_BITS = 16;
    localparam int ONE_INT   = 1 << FRAC_BITS;

    localparam int IN_W   = 18;                     // intensity width
    localparam int MAG_W  = IN_W - 1;               // magnitude of a non-negative intensity
    localparam int CNT_W  = 3;                      // stop count register
    localparam int POS_W  = MAG_W + CNT_W;          // intensity * segments
    localparam int SEG_W  = POS_W - FRAC_BITS;      // integer part of position
    localparam int IDX_W  = $clog2(MAX_STOPS);      // stop index
    localparam int FRAC_W = FRAC_BITS + 1;          // fraction incl. full weight
    localparam int CH_W   = 8;                      // one colour channel
    localparam int RGB_W  = 3 * CH_W;
    localparam int PROD_W = CH_W + FRAC_BITS;       // channel * weight
    localparam int REG_W  = RGB_W;                  // widest config register
    localparam int RIDX_W = 3;                      // config register index

    // Config register map
    localparam logic [RIDX_W-1:0] REG_STOP_COUNT = RIDX_W'(0);
    localparam logic [RIDX_W-1:0] REG_COLOR_BASE = RIDX_W'(1);

    // Reset values
    localparam logic [CNT_W-1:0] RST_STOP_COUNT = CNT_W'(2);
    localparam logic [RGB_W-1:0] RST_COLOR_HI   = {RGB_W{1'b1}};

    typedef logic [RGB_W-1:0] t_rgb;

    // Per-stage advance enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

[sv/gpl_cfg_regs.sv]
// Configuration registers: stop count and the colour stop table
module gpl_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gpl_pkg::RIDX_W-1:0]  i_cfg_index,
    input  logic [gpl_pkg::REG_W-1:0]   i_cfg_data,
    output logic [gpl_pkg::CNT_W-1:0]   o_stop_count,
    output gpl_pkg::t_rgb               o_colors [gpl_pkg::MAX_STOPS]
);
    import gpl_pkg::*;

    logic [CNT_W-1:0] r_stop_count;
    t_rgb             r_colors [MAX_STOPS];
    logic [RIDX_W-1:0] color_idx;

    assign color_idx = i_cfg_index - REG_COLOR_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= RST_STOP_COUNT;
            for (int k = 0; k < MAX_STOPS; k++) begin
                r_colors[k] <= (k == 1) ? RST_COLOR_HI : '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_STOP_COUNT) begin
                r_stop_count <= i_cfg_data[CNT_W-1:0];
            end else if (color_idx < RIDX_W'(MAX_STOPS)) begin
                r_colors[color_idx[IDX_W-1:0]] <= i_cfg_data[RGB_W-1:0];
            end
        end
    end

    assign o_stop_count = r_stop_count;
    assign o_colors     = r_colors;

endmodule

[sv/gpl_front.sv]
// Stages 1-2: range check, position scaling, segment decode and stop select
module gpl_front (
    input  logic                        i_clk,
    input  gpl_pkg::t_pipe_en           i_en,
    input  logic signed [gpl_pkg::IN_W-1:0] i_intensity,
    input  logic [gpl_pkg::CNT_W-1:0]   i_stop_count,
    input  gpl_pkg::t_rgb               i_colors [gpl_pkg::MAX_STOPS],
    output gpl_pkg::t_rgb               o_lo,
    output gpl_pkg::t_rgb               o_hi,
    output logic [gpl_pkg::FRAC_W-1:0]  o_frac,
    output logic                        o_ok
);
    import gpl_pkg::*;

    // stage 1
    logic [CNT_W-1:0] n_count;
    logic [MAG_W-1:0] mag;
    logic             n_ok1;
    logic [CNT_W-1:0] n_segs;
    logic [POS_W-1:0] n_pos;
    logic             r_ok1;
    logic [CNT_W-1:0] r_segs;
    logic [POS_W-1:0] r_pos;

    // stage 2
    logic [SEG_W-1:0]  seg;
    logic [FRAC_W-1:0] frac;
    logic [IDX_W-1:0]  idx_lo;
    logic [IDX_W-1:0]  idx_hi;
    t_rgb              n_lo;
    t_rgb              n_hi;
    t_rgb              r_lo;
    t_rgb              r_hi;
    logic [FRAC_W-1:0] r_frac;
    logic              r_ok2;

    always_comb begin
        mag     = i_intensity[MAG_W-1:0];
        n_count = (i_stop_count > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : i_stop_count;
        n_ok1   = !i_intensity[IN_W-1] && (mag <= MAG_W'(ONE_INT))
                  && (n_count >= CNT_W'(2));
        if (n_ok1) begin
            n_segs = n_count - CNT_W'(1);
            n_pos  = POS_W'(POS_W'(mag) * POS_W'(n_segs));
        end else begin
            // park on a harmless segment; colours are forced to black later
            n_segs = CNT_W'(1);
            n_pos  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_ok1  <= n_ok1;
            r_segs <= n_segs;
            r_pos  <= n_pos;
        end
    end

    always_comb begin
        seg  = r_pos[POS_W-1:FRAC_BITS];
        frac = {1'b0, r_pos[FRAC_BITS-1:0]};
        // on an interior stop: lower segment, full weight
        if (r_pos[FRAC_BITS-1:0] == '0 && seg != '0) begin
            seg  = seg - SEG_W'(1);
            frac = FRAC_W'(ONE_INT);
        end
        if (seg >= SEG_W'(r_segs)) begin
            seg  = SEG_W'(r_segs) - SEG_W'(1);
            frac = FRAC_W'(ONE_INT);
        end
        idx_lo = seg[IDX_W-1:0];
        idx_hi = idx_lo + IDX_W'(1);
        n_lo   = r_ok1 ? i_colors[idx_lo] : '0;
        n_hi   = r_ok1 ? i_colors[idx_hi] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_frac <= frac;
            r_ok2  <= r_ok1;
        end
    end

    assign o_lo   = r_lo;
    assign o_hi   = r_hi;
    assign o_frac = r_frac;
    assign o_ok   = r_ok2;

endmodule

[sv/gpl_blend.sv]
// Stages 3-4: weighted products and truncating sum for one colour channel
module gpl_blend (
    input  logic                        i_clk,
    input  gpl_pkg::t_pipe_en           i_en,
    input  logic [gpl_pkg::CH_W-1:0]    i_lo,
    input  logic [gpl_pkg::CH_W-1:0]    i_hi,
    input  logic [gpl_pkg::FRAC_W-1:0]  i_frac,
    output logic [gpl_pkg::CH_W-1:0]    o_chan
);
    import gpl_pkg::*;

    logic [PROD_W-1:0] n_plo;
    logic [PROD_W-1:0] n_phi;
    logic [PROD_W-1:0] r_plo;
    logic [PROD_W-1:0] r_phi;
    logic [PROD_W:0]   sum;
    logic [CH_W-1:0]   r_chan;

    always_comb begin
        n_plo = PROD_W'(PROD_W'(i_lo) * PROD_W'(FRAC_W'(ONE_INT) - i_frac));
        n_phi = PROD_W'(PROD_W'(i_hi) * PROD_W'(i_frac));
        sum   = {1'b0, r_plo} + {1'b0, r_phi};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_plo <= n_plo;
            r_phi <= n_phi;
        end
        if (i_en.s4) begin
            r_chan <= sum[FRAC_BITS +: CH_W];
        end
    end

    assign o_chan = r_chan;

endmodule

[sv/gradient_palette_lookup.sv]
// Gradient palette lookup: intensity to interpolated RGB through evenly spaced stops
// An accepted request moves through stages 1 to 3 into the output register, stage 4.
// Throughput: one request per cycle; the four stages advance independently, so bubbles
// close up and requests are taken while the output waits, until every stage is full.
// Reset (synchronous, active low) empties the pipeline and restores the default
// palette: two stops, black to white.
module gradient_palette_lookup (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [gpl_pkg::IN_W-1:0] i_intensity,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [gpl_pkg::CH_W-1:0]    o_red,
    output logic [gpl_pkg::CH_W-1:0]    o_green,
    output logic [gpl_pkg::CH_W-1:0]    o_blue,
    output logic                        o_in_range,
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic [gpl_pkg::RIDX_W-1:0]  i_cfg_index,
    input  logic [gpl_pkg::REG_W-1:0]   i_cfg_data
);
    import gpl_pkg::*;

    logic [CNT_W-1:0]  stop_count;
    t_rgb              colors [MAX_STOPS];
    t_pipe_en          en;
    t_rgb              lo;
    t_rgb              hi;
    logic [FRAC_W-1:0] frac;
    logic              ok2;

    // Valid bit per stage; stage 4 is the output register
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_ok3, r_ok4;

    // A stage moves on when it is empty or the stage after it moves on
    always_comb begin
        en.s4 = !r_v4 || i_ready;
        en.s3 = !r_v3 || en.s4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    assign o_ready = en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= i_valid;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en.s4) r_v4 <= r_v3;
        end
    end

    // in_range flag rides alongside the channel arithmetic
    always_ff @(posedge i_clk) begin
        if (en.s3) r_ok3 <= ok2;
        if (en.s4) r_ok4 <= r_ok3;
    end

    gpl_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_stop_count (stop_count),
        .o_colors     (colors)
    );

    // Out-of-range requests leave the front with both stops black
    gpl_front u_front (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_intensity  (i_intensity),
        .i_stop_count (stop_count),
        .i_colors     (colors),
        .o_lo         (lo),
        .o_hi         (hi),
        .o_frac       (frac),
        .o_ok         (ok2)
    );

    gpl_blend u_red (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lo   (lo[2*CH_W +: CH_W]),
        .i_hi   (hi[2*CH_W +: CH_W]),
        .i_frac (frac),
        .o_chan (o_red)
    );

    gpl_blend u_green (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lo   (lo[CH_W +: CH_W]),
        .i_hi   (hi[CH_W +: CH_W]),
        .i_frac (frac),
        .o_chan (o_green)
    );

    gpl_blend u_blue (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lo   (lo[0 +: CH_W]),
        .i_hi   (hi[0 +: CH_W]),
        .i_frac (frac),
        .o_chan (o_blue)
    );

    assign o_valid    = r_v4;
    assign o_in_range = r_ok4;

endmodule

[sv/gpl_checker.sv]
// Port-level checker for the palette lookup, bound to the top level
`include "gradient_palette_lookup_assert.svh"

module gpl_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_ready,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [gpl_pkg::CH_W-1:0]    o_red,
    input  logic [gpl_pkg::CH_W-1:0]    o_green,
    input  logic [gpl_pkg::CH_W-1:0]    o_blue,
    input  logic                        o_in_range
);
    import gpl_pkg::*;

    logic [RGB_W-1:0] rgb;
    logic [RGB_W:0]   pixel;

    assign rgb   = {o_red, o_green, o_blue};
    assign pixel = {rgb, o_in_range};

    // invalid colour is always black
    `GPL_ASSERT_IMP(a_black_out_of_range, o_valid && !o_in_range, rgb == '0)

    // the front only backs up once every stage is full and the output stalls
    `GPL_ASSERT_IMP(a_stall_only_when_full, !o_ready, o_valid && !i_ready)

    // a stalled result holds
    `GPL_ASSERT_NEXT(a_result_holds, o_valid && !i_ready, o_valid && $stable(pixel))

endmodule

bind gradient_palette_lookup gpl_checker u_gpl_checker (.*);

[tb/tb.sv]
// Self-checking testbench for the gradient palette lookup
`timescale 1ns / 1ps

module tb;
    import gpl_pkg::*;

    localparam int LATENCY     = 3;     // request to result, through the pipeline stages
    localparam int HOLD_CYCLES = 80;    // long output back-pressure stretch
    localparam int IDLE_LIMIT  = 1000;  // cycles with no transfer before giving up
    localparam int MAX_REPORTS = 10;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 52;

    // Per-stop register indexes
    localparam logic [RIDX_W-1:0] REG_STOP_0 = REG_COLOR_BASE;
    localparam logic [RIDX_W-1:0] REG_STOP_1 = REG_COLOR_BASE + RIDX_W'(1);
    localparam logic [RIDX_W-1:0] REG_STOP_2 = REG_COLOR_BASE + RIDX_W'(2);
    localparam logic [RIDX_W-1:0] REG_STOP_3 = REG_COLOR_BASE + RIDX_W'(3);
    localparam logic [RIDX_W-1:0] REG_STOP_4 = REG_COLOR_BASE + RIDX_W'(4);
    localparam logic [RIDX_W-1:0] REG_STOP_5 = REG_COLOR_BASE + RIDX_W'(5);
    localparam logic [RIDX_W-1:0] REG_STOP_6 = REG_COLOR_BASE + RIDX_W'(6);

    // One output pixel; packed so a typed row converts straight across
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            in_range;
    } t_pixel;

    // Directed rows: either a register write or a request
    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [RIDX_W-1:0]  idx;        // register index, cfg rows only
        logic [REG_W-1:0]   val;        // register data, or intensity in the low bits
        logic               chk;        // expected pixel typed in below
        logic [RGB_W-1:0]   rgb;
        logic               in_range;
    } t_row;

    localparam int N_DIR = 36;

    // Expected pixels are typed where obvious: defaults, range edges, exact stops.
    // Other rows go through the predictor.
    t_row dir_tab [N_DIR] = '{
        // reset palette: two stops, black to white
        '{ROW_ITEM, '0, 24'(0),       1'b1, 24'h000000, 1'b1},
        '{ROW_ITEM, '0, 24'(65536),   1'b1, 24'hFFFFFF, 1'b1},
        '{ROW_ITEM, '0, 24'(32768),   1'b1, 24'h7F7F7F, 1'b1},
        '{ROW_ITEM, '0, 24'(1),       1'b1, 24'h000000, 1'b1},
        '{ROW_ITEM, '0, 24'(65535),   1'b1, 24'hFEFEFE, 1'b1},
        // just outside 0..1 and the field extremes: black, not in range
        '{ROW_ITEM, '0, 24'(-1),      1'b1, 24'h000000, 1'b0},
        '{ROW_ITEM, '0, 24'(65537),   1'b1, 24'h000000, 1'b0},
        '{ROW_ITEM, '0, 24'(131071),  1'b1, 24'h000000, 1'b0},
        '{ROW_ITEM, '0, 24'(-131072), 1'b1, 24'h000000, 1'b0},
        // three stops: red, green, blue
        '{ROW_CFG, REG_STOP_0,     24'hFF0000, 1'b0, 24'h0, 1'b0},
        '{ROW_CFG, REG_STOP_1,     24'h00FF00, 1'b0, 24'h0, 1'b0},
        '{ROW_CFG, REG_STOP_2,     24'h0000FF, 1'b0, 24'h0, 1'b0},
        '{ROW_CFG, REG_STOP_COUNT, 24'd3,      1'b0, 24'h0, 1'b0},
        '{ROW_ITEM, '0, 24'(32768),   1'b1, 24'h00FF00, 1'b1},  // on the interior stop
        '{ROW_ITEM, '0, 24'(0),       1'b1, 24'hFF0000, 1'b1},
        '{ROW_ITEM, '0, 24'(65536),   1'b1, 24'h0000FF, 1'b1},
        '{ROW_ITEM, '0, 24'(16384),   1'b0, 24'h0, 1'b0},
        '{ROW_ITEM, '0, 24'(49152),   1'b0, 24'h0, 1'b0},
        // full palette of seven stops
        '{ROW_CFG, REG_STOP_0,     24'h123456, 1'b0, 24'h0, 1'b0},
        '{ROW_CFG, REG_STOP_1,     24'hFFFFFF, 1'b0, 24'h0, 1'b0},
        '{ROW_CFG, REG_STOP_2,     24'h000000, 1'b0, 24'h0, 1'b0},
        '{ROW_CFG, REG_STOP_3,     24'h80FF01, 1'b0, 24'h0, 1'b0},
        '{ROW_CFG, REG_STOP_4,     24'h7F00FE, 1'b0, 24'h0, 1'b0},
        '{ROW_CFG, REG_STOP_5,     24'hA5A5A5, 1'b0, 24'h0, 1'b0},
        '{ROW_CFG, REG_STOP_6,     24'h5A3C0F, 1'b0, 24'h0, 1'b0},
        '{ROW_CFG, REG_STOP_COUNT, 24'd7,      1'b0, 24'h0, 1'b0},
        '{ROW_ITEM, '0, 24'(32768),   1'b1, 24'h80FF01, 1'b1},  // exactly stop 3
        '{ROW_ITEM, '0, 24'(65536),   1'b1, 24'h5A3C0F, 1'b1},
        '{ROW_ITEM, '0, 24'(0),       1'b1, 24'h123456, 1'b1},
        '{ROW_ITEM, '0, 24'(10923),   1'b0, 24'h0, 1'b0},
        '{ROW_ITEM, '0, 24'(12345),   1'b0, 24'h0, 1'b0},
        // too few stops: no palette at all
        '{ROW_CFG, REG_STOP_COUNT, 24'd1,      1'b0, 24'h0, 1'b0},
        '{ROW_ITEM, '0, 24'(32768),   1'b1, 24'h000000, 1'b0},
        '{ROW_ITEM, '0, 24'(0),       1'b1, 24'h000000, 1'b0},
        '{ROW_CFG, REG_STOP_COUNT, 24'd0,      1'b0, 24'h0, 1'b0},
        '{ROW_ITEM, '0, 24'(65536),   1'b1, 24'h000000, 1'b0}
    };

    // DUT ports; the inputs are driven to known values from time zero
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     o_ready;
    logic signed [IN_W-1:0]   i_intensity = '0;
    logic                     o_valid;
    logic                     i_ready     = 1'b0;
    logic [CH_W-1:0]          o_red;
    logic [CH_W-1:0]          o_green;
    logic [CH_W-1:0]          o_blue;
    logic                     o_in_range;
    logic                     i_cfg_we    = 1'b0;
    logic [RIDX_W-1:0]        i_cfg_index = '0;
    logic [REG_W-1:0]         i_cfg_data  = '0;

    // Testbench copy of the configuration
    logic [CNT_W-1:0] stop_cnt;
    t_rgb             palette [MAX_STOPS];

    t_pixel      due_pixels [$];   // expected pixels, oldest first
    int unsigned bad_pixels = 0;
    int unsigned idle_cycles = 0;
    bit          calm = 1'b0;      // both sides run flat out
    bit          hold_req = 1'b0;  // asks the receiver for one long hold-off

    gradient_palette_lookup DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_intensity (i_intensity),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_in_range  (o_in_range),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Linear blend of one channel, truncated
    function automatic logic [CH_W-1:0] mix(input logic [CH_W-1:0] lo,
                                            input logic [CH_W-1:0] hi,
                                            input int unsigned     frac);
        int unsigned acc;
        acc = int'(lo) * (ONE_INT - frac) + int'(hi) * frac;
        return CH_W'(acc >> FRAC_BITS);
    endfunction

    // Predicted pixel for one intensity under the current palette
    function automatic t_pixel shade(input logic [IN_W-1:0] x);
        int unsigned n, segs, pos, seg, frac;
        t_rgb        lo_c, hi_c;
        t_pixel      p;
        p = '0;
        n = stop_cnt;
        if (n > MAX_STOPS)
            n = MAX_STOPS;
        if (x[IN_W-1] || x > ONE_INT || n < 2)
            return p;
        segs = n - 1;
        pos  = x * segs;
        seg  = pos >> FRAC_BITS;
        frac = pos & (ONE_INT - 1);
        // a position on an interior stop belongs to the lower segment
        if (frac == 0 && seg > 0) begin
            seg  = seg - 1;
            frac = ONE_INT;
        end
        if (seg >= segs) begin
            seg  = segs - 1;
            frac = ONE_INT;
        end
        lo_c = palette[seg];
        hi_c = palette[seg + 1];
        p.red      = mix(lo_c[23:16], hi_c[23:16], frac);
        p.green    = mix(lo_c[15:8],  hi_c[15:8],  frac);
        p.blue     = mix(lo_c[7:0],   hi_c[7:0],   frac);
        p.in_range = 1'b1;
        return p;
    endfunction

    // Register write while the block is idle; the copy follows at once
    task automatic cfg_write(input logic [RIDX_W-1:0] idx, input logic [REG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == REG_STOP_COUNT)
            stop_cnt = data[CNT_W-1:0];
        else
            palette[idx - REG_COLOR_BASE] = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one request after a random gap; queue its pixel once taken.
    // Valid stays up across back-to-back requests, only the payload moves.
    task automatic push_intensity(input logic [IN_W-1:0] x, input bit chk,
                                  input t_pixel typed);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_intensity <= x;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        due_pixels.push_back(chk ? typed : shade(x));
    endtask

    // Stop offering and wait until every queued pixel has come back
    task automatic wait_pixels_out();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (due_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    // Request side: directed rows, then random phases under fresh palettes
    initial begin
        int unsigned  p, i, k, segs, sel, cnt;
        logic [IN_W-1:0] x;
        t_rgb         col;

        stop_cnt = RST_STOP_COUNT;
        foreach (palette[j])
            palette[j] = '0;
        palette[1] = RST_COLOR_HI;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                wait_pixels_out();
                cfg_write(dir_tab[r].idx, dir_tab[r].val);
            end else begin
                push_intensity(dir_tab[r].val[IN_W-1:0], dir_tab[r].chk,
                               t_pixel'({dir_tab[r].rgb, dir_tab[r].in_range}));
            end
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            // idle between phases: every pixel back before the palette moves
            wait_pixels_out();
            for (k = 0; k < MAX_STOPS; k++) begin
                if (p == 0)
                    col = k[0] ? 24'h000000 : 24'hFFFFFF;
                else if (p == 1 && k < 2)
                    col = (k == 0) ? 24'hFFFFFF : 24'h000000;
                else
                    col = RGB_W'($urandom);
                cfg_write(RIDX_W'(REG_COLOR_BASE + k), col);
            end
            if (p == 0)
                cnt = MAX_STOPS;
            else if (p == 1)
                cnt = 2;
            else if ($urandom_range(0, 7) == 0)
                cnt = $urandom_range(0, 1);
            else
                cnt = $urandom_range(2, MAX_STOPS);
            // upper data bits are don't-care for the count register
            cfg_write(REG_STOP_COUNT, {21'($urandom), CNT_W'(cnt)});

            calm = (p % 4 == 3) || (p == 2);
            // long output stall with requests still coming: fills the pipe
            if (p == 2)
                hold_req = 1'b1;

            segs = (stop_cnt >= 2) ? stop_cnt - 1 : 1;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                sel = $urandom_range(0, 19);
                if (sel < 10) begin
                    x = IN_W'($urandom_range(0, ONE_INT));
                end else if (sel < 14) begin
                    // at or next to a stop position
                    k = $urandom_range(0, segs);
                    x = IN_W'((k * ONE_INT + ($urandom_range(0, 1) ? segs - 1 : 0)) / segs);
                    x = x + IN_W'($urandom_range(0, 2)) - IN_W'(1);
                end else if (sel < 16) begin
                    x = IN_W'(ONE_INT + $urandom_range(1, 3));
                end else if (sel < 17) begin
                    x = IN_W'(0) - IN_W'($urandom_range(1, 3));
                end else begin
                    x = IN_W'($urandom);
                end
                push_intensity(x, 1'b0, '0);
            end
        end

        wait_pixels_out();
        // catch stragglers after the last expected pixel
        repeat (2 * LATENCY) @(posedge i_clk);
        if (due_pixels.size() != 0) begin
            bad_pixels = bad_pixels + due_pixels.size();
            $display("%0d pixels never arrived", due_pixels.size());
        end
        if (bad_pixels == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Result side: random stall per pixel, one long hold-off on request
    initial begin
        int unsigned stall;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end else begin
                stall = calm ? 0 : $urandom_range(0, 4);
            end
            if (stall != 0) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // Compare each delivered pixel with the oldest expectation
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_pixels.size() == 0) begin
                bad_pixels++;
                if (bad_pixels <= MAX_REPORTS)
                    $display("%0t: unexpected pixel %02h %02h %02h in_range %0b",
                             $time, o_red, o_green, o_blue, o_in_range);
            end else begin
                want = due_pixels.pop_front();
                if (o_red !== want.red || o_green !== want.green ||
                    o_blue !== want.blue || o_in_range !== want.in_range) begin
                    bad_pixels++;
                    if (bad_pixels <= MAX_REPORTS)
                        $display({"%0t: pixel mismatch, expected %02h %02h %02h in_range %0b,",
                                  " got %02h %02h %02h in_range %0b"},
                                 $time, want.red, want.green, want.blue, want.in_range,
                                 o_red, o_green, o_blue, o_in_range);
                end
            end
        end
    end

    // Watchdog: too long without a transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

[sim.f]
+incdir+sv
sv/gpl_pkg.sv
sv/gpl_cfg_regs.sv
sv/gpl_front.sv
sv/gpl_blend.sv
sv/gradient_palette_lookup.sv
sv/gpl_checker.sv
tb/tb.sv
